FILE: hw/rtl/searchable_lifo_stack_defines.svh
// Assertion helpers used by the checker file.
`ifndef SEARCHABLE_LIFO_STACK_DEFINES_SVH
`define SEARCHABLE_LIFO_STACK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sls_pkg.sv
`timescale 1ns / 1ps

package sls_pkg;

    typedef enum logic [2:0]
    {
        KIND_PUSH  = 3'd0,
        KIND_POP   = 3'd1,
        KIND_FIND  = 3'd2,
        KIND_READ  = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Shift command that every cell of the stack sees in the same cycle.
    typedef struct packed
    {
        logic push;
        logic pop;
    } sls_shift_t;

endpackage

FILE: hw/rtl/sls_cell.sv
`timescale 1ns / 1ps

module sls_cell
(
    input  logic               clk,
    input  sls_pkg::sls_shift_t ctl,
    input  logic [31:0]        word_above,
    input  logic [31:0]        word_below,
    input  logic [31:0]        key,
    output logic [31:0]        word,
    output logic               hit
);
    import sls_pkg::*;

    logic [31:0] word_reg;

    // A push moves every word one place down, a pop one place up.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            word_reg <= word_above;
        end
        else if (ctl.pop)
        begin
            word_reg <= word_below;
        end
    end

    assign word = word_reg;
    assign hit  = (word_reg == key);

endmodule

FILE: hw/rtl/searchable_lifo_stack.sv
// Results are registered: a result is presented in the cycle after its input transfer.
// Throughput: one operation per cycle while the output is not stalled; every operation,
// the value search included, is done in a single pass over the row of cells.
// Reset clears the word count and the output valid; the cell contents
// stay undefined and are only read below the word count.
`timescale 1ns / 1ps

module searchable_lifo_stack
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] operand,
    input  logic [5:0]  index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] item_value,
    output logic [5:0]  position,
    output logic [6:0]  depth,
    output logic [31:0] top_value,
    output logic        is_empty
);
    import sls_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int RDN  = (DEPTH < 64) ? DEPTH : 64;

    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           out_valid_reg;
    status_t        status_reg;
    status_t        status_next;
    logic [31:0]    item_reg;
    logic [31:0]    item_next;
    logic [5:0]     pos_reg;
    logic [5:0]     pos_next;
    logic [6:0]     depth_reg;
    logic [31:0]    top_reg;
    logic [31:0]    top_next;
    logic           empty_reg;

    logic           accept;
    logic           full;
    logic           empty;
    logic           push_ok;
    logic           pop_ok;
    sls_shift_t     shift_ctl;
    logic [31:0]    cell_word [DEPTH];
    logic [DEPTH-1:0] cell_hit;
    logic [DEPTH-1:0] live_hit;
    logic           found;
    logic [5:0]     found_pos;
    logic [31:0]    rd_word;
    logic           rd_ok;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign push_ok  = accept && (kind_t'(kind) == KIND_PUSH) && !full;
    assign pop_ok   = accept && (kind_t'(kind) == KIND_POP) && !empty;

    assign shift_ctl.push = push_ok;
    assign shift_ctl.pop  = pop_ok;

    // Cell 0 holds the top of the stack.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [31:0] above;
            logic [31:0] below;

            if (g == 0)
            begin : g_first
                assign above = operand;
            end
            else
            begin : g_mid
                assign above = cell_word[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign below = cell_word[g];
            end
            else
            begin : g_inner
                assign below = cell_word[g+1];
            end

            sls_cell u_cell
            (
                .clk        (clk),
                .ctl        (shift_ctl),
                .word_above (above),
                .word_below (below),
                .key        (operand),
                .word       (cell_word[g]),
                .hit        (cell_hit[g])
            );

            assign live_hit[g] = cell_hit[g] && (CW'(g) < cnt_reg);
        end
    endgenerate

    // The match nearest the top wins.
    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (live_hit[i])
            begin
                found     = 1'b1;
                found_pos = 6'(i);
            end
        end
    end

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < RDN; i++)
        begin
            if (index == 6'(i))
            begin
                rd_word = cell_word[i];
            end
        end
    end

    assign rd_ok = (CMPW'(index) < CMPW'(cnt_reg));

    always_comb
    begin
        status_next = ST_DONE;
        item_next   = '0;
        pos_next    = '0;
        cnt_next    = cnt_reg;
        top_next    = empty ? 32'd0 : cell_word[0];
        unique case (kind_t'(kind))
            KIND_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                    top_next = operand;
                end
            end
            KIND_POP:
            begin
                if (empty)
                begin
                    status_next = ST_NONE;
                end
                else
                begin
                    cnt_next  = cnt_reg - CW'(1);
                    item_next = cell_word[0];
                    top_next  = (cnt_reg > CW'(1)) ? cell_word[1] : 32'd0;
                end
            end
            KIND_FIND:
            begin
                if (found)
                begin
                    item_next = operand;
                    pos_next  = found_pos;
                end
                else
                begin
                    status_next = ST_NONE;
                end
            end
            KIND_READ:
            begin
                if (rd_ok)
                begin
                    item_next = rd_word;
                    pos_next  = index;
                end
                else
                begin
                    status_next = ST_NONE;
                end
            end
            KIND_CLEAR:
            begin
                cnt_next = '0;
                top_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            item_reg   <= item_next;
            pos_reg    <= pos_next;
            depth_reg  <= 7'(cnt_next);
            top_reg    <= top_next;
            empty_reg  <= (cnt_next == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign item_value = item_reg;
    assign position   = pos_reg;
    assign depth      = depth_reg;
    assign top_value  = top_reg;
    assign is_empty   = empty_reg;

endmodule

FILE: hw/rtl/sls_checker.sv
`timescale 1ns / 1ps
`include "searchable_lifo_stack_defines.svh"

module sls_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  kind,
    input logic [31:0] operand,
    input logic [5:0]  index,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] item_value,
    input logic [5:0]  position,
    input logic [6:0]  depth,
    input logic [31:0] top_value,
    input logic        is_empty
);
    import sls_pkg::*;

    `SLS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
    `SLS_ASSERT_SAME(a_empty_flag, clk, rst_n, out_valid, is_empty == (depth == 7'd0), "empty flag disagrees with depth")
    `SLS_ASSERT_SAME(a_empty_top, clk, rst_n, out_valid && is_empty, top_value == 32'd0, "empty stack shows a top word")
    `SLS_ASSERT_SAME(a_full_nonempty, clk, rst_n, out_valid && (status == ST_FULL), !is_empty, "refused push on an empty stack")
    `SLS_ASSERT_NEXT(a_push_top, clk, rst_n, in_valid && !in_stall && (kind == KIND_PUSH), (status == ST_FULL) || (top_value == $past(operand)), "pushed word is not on top")

endmodule

bind searchable_lifo_stack sls_checker u_sls_checker (.*);
